// ===== src/sorted_list_insert_top_assert.svh =====
// ---------------------------------------------------------------------------
// sorted_list_insert_top_assert.svh
// assertion macros for the sorted insertion list
// ---------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_TOP_ASSERT_SVH
`define SORTED_LIST_INSERT_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// property that must hold at every edge outside reset
`define SLI_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition at one edge implies expression at the next edge
`define SLI_ASSERT_NEXT(lbl, cond, expr, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) else $error(msg);

`else

`define SLI_ASSERT(lbl, prop, msg)
`define SLI_ASSERT_NEXT(lbl, cond, expr, msg)

`endif

`endif

// ===== src/sli_pkg.sv =====
// ---------------------------------------------------------------------------
// sli_pkg
// shared types and codes for the sorted insertion list
// ---------------------------------------------------------------------------
`default_nettype none

package sli_pkg;

   localparam int DATA_W = 32;

   // command codes carried in req_tuser
   localparam logic CMD_INSERT  = 1'b0;
   localparam logic CMD_READOUT = 1'b1;

   // result kind carried in rsp_tuser
   typedef enum logic [1:0] {
      STAT_INSERTED = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_ELEMENT  = 2'd2,
      STAT_EMPTY    = 2'd3
   } status_type;

   // control sequencer states
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_READ = 1'b1
   } state_type;

   // one stored entry as seen by a neighbor
   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] value;
   } cell_data_type;

   // operation broadcast to every cell
   typedef struct packed {
      logic                     insert;
      logic                     rotate;
      logic signed [DATA_W-1:0] value;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== src/sli_cell.sv =====
// ---------------------------------------------------------------------------
// sli_cell
// one slot of the sorted chain: compares, keeps, takes the new value or
// shifts in from a neighbor
// ---------------------------------------------------------------------------
`default_nettype none

module sli_cell (
   input  wire                   clock,
   input  wire                   reset,
   input  wire sli_pkg::cell_ctrl_type ctrl,
   input  wire sli_pkg::cell_data_type prev_data,   // neighbor toward the head
   input  wire                   prev_less,   // head cell sees 1 here
   input  wire sli_pkg::cell_data_type next_data,   // rotation source
   output sli_pkg::cell_data_type data,
   output logic                  less
);
   import sli_pkg::*;

   logic                     valid_ff, valid_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic                     take_new;

   // stored value strictly below the incoming one stays put
   assign less     = valid_ff && (value_ff < ctrl.value);
   assign take_new = !less && prev_less;

   assign data.valid = valid_ff;
   assign data.value = value_ff;

   // next slot content
   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctrl.insert) begin
         if (take_new) begin
            valid_in = 1'b1;
            value_in = ctrl.value;
         end else if (!less) begin
            valid_in = prev_data.valid;
            value_in = prev_data.value;
         end
      end else if (ctrl.rotate) begin
         valid_in = next_data.valid;
         value_in = next_data.value;
      end
   end

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

// ===== src/sorted_list_insert_top.sv =====
// ---------------------------------------------------------------------------
// sorted_list_insert_top
// bounded ascending list of signed 32-bit values in a chain of cells
// ---------------------------------------------------------------------------
// Usage: each req transaction carries a command in req_tuser and a value in
// req_tdata. An insert is compared against every cell at once and, unless
// the list is full, the chain shifts; its single result (inserted or full)
// appears on the rsp channel in the cycle after acceptance. While the rsp
// channel is free, inserts run at one per cycle.
// A readout rotates the whole chain toward the head, one step per cycle while
// the rsp channel is free, and emits the head cell whenever it holds an entry:
// the stored values come out in ascending order, the last one with rsp_tlast
// set. A readout occupies the block for a full turn of the chain, which
// restores the order; req_tready is low during that time. A readout of an
// empty list gives one result with status empty in the next cycle.
// The rsp channel has one output register; while a result waits there with
// rsp_tready low, the chain does not step and no new request is accepted.
// Reset (synchronous, active high) empties the list and clears the channel.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_list_insert_top #(
   parameter int CAPACITY = 16
) (
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // [31:0] value
   input  wire  [0:0]  req_tuser,   // [0] cmd
   // result channel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] value_out
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast    // last
);
   import sli_pkg::*;

   `include "sorted_list_insert_top_assert.svh"

   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int STEP_W = $clog2(CAPACITY);

   // chain wiring
   cell_ctrl_type ctrl;
   cell_data_type cell_q [CAPACITY];
   logic          less_vec [CAPACITY];
   logic [CAPACITY-1:0] valid_vec;

   // control
   state_type   state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic out_free, req_accept, full, do_insert;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic                     rsp_load;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && out_free;
   assign req_accept = req_tvalid && req_tready;
   assign full       = (count_ff == CNT_W'(CAPACITY));
   assign do_insert  = req_accept && (req_tuser[0] == CMD_INSERT) && !full;

   assign ctrl.insert = do_insert;
   assign ctrl.rotate = (state_ff == ST_READ) && out_free;
   assign ctrl.value  = $signed(req_tdata);

   // row of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      cell_data_type prev_d, next_d;
      logic          prev_l;
      if (i == 0) begin : g_head
         assign prev_d = '0;
         assign prev_l = 1'b1;
      end else begin : g_body
         assign prev_d = cell_q[i-1];
         assign prev_l = less_vec[i-1];
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign next_d = cell_q[0];
      end else begin : g_mid
         assign next_d = cell_q[i+1];
      end
      sli_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .prev_data (prev_d),
         .prev_less (prev_l),
         .next_data (next_d),
         .data      (cell_q[i]),
         .less      (less_vec[i])
      );
      assign valid_vec[i] = cell_q[i].valid;
   end

   // sequencer and result selection
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      rsp_load      = 1'b0;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               rsp_last_in = 1'b1;
               if (req_tuser[0] == CMD_INSERT) begin
                  rsp_load      = 1'b1;
                  rsp_value_in  = $signed(req_tdata);
                  rsp_status_in = full ? STAT_FULL : STAT_INSERTED;
                  if (!full) begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end else if (count_ff == '0) begin
                  rsp_load      = 1'b1;
                  rsp_value_in  = '0;
                  rsp_status_in = STAT_EMPTY;
               end else begin
                  state_in = ST_READ;
                  step_in  = '0;
               end
            end
         end
         ST_READ: begin
            if (out_free) begin
               if (cell_q[0].valid) begin
                  rsp_load      = 1'b1;
                  rsp_value_in  = cell_q[0].value;
                  rsp_status_in = STAT_ELEMENT;
                  rsp_last_in   = ({1'b0, step_ff} + (STEP_W+1)'(1))
                                  == (STEP_W+1)'(count_ff);
               end
               if (step_ff == STEP_W'(CAPACITY - 1)) begin
                  state_in = ST_IDLE;
               end else begin
                  step_in = step_ff + STEP_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   // checks
   `SLI_ASSERT(a_count_bound, count_ff <= CNT_W'(CAPACITY), "entry count above capacity")
   `SLI_ASSERT(a_valid_prefix, $countones(valid_vec) == count_ff, "valid cells differ from count")
   `SLI_ASSERT(a_read_blocks, (state_ff == ST_READ) |-> !req_tready, "request taken during readout")
   `SLI_ASSERT_NEXT(a_insert_count, do_insert, count_ff == $past(count_ff) + CNT_W'(1), "insert did not bump count")

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// stream-level testbench for the sorted insertion list
// ----------------------------------------------------------------------------
// Sends insert and readout commands and predicts every result in a small
// scoreboard that keeps its own ascending copy of the list. Each result on
// the rsp channel is checked in order against the prediction. A directed
// opening covers the empty-list readout, the value extremes and equal
// values. A random stretch follows, with bursty traffic on the request side
// and a changing stall pattern on the result side. The random stretch also
// has one long result hold-off while requests keep coming, and one pause
// that waits for every pending result.
// ----------------------------------------------------------------------------

package sli_tb_pkg;

   import sli_pkg::*;

   // list depth shared by the scoreboard and the block under test
   localparam int SB_DEPTH = 16;

   // one predicted rsp transaction
   typedef struct {
      logic signed [DATA_W-1:0] value;
      status_type               status;
      logic                     last;
   } list_result_type;

   class list_scoreboard;

      localparam int DEPTH = SB_DEPTH;

      logic signed [DATA_W-1:0] entries [DEPTH];
      int                       count;
      list_result_type          expected_q [$];
      int unsigned              mismatches;

      function new();
         count      = 0;
         mismatches = 0;
      endfunction

      function void push_result(logic signed [DATA_W-1:0] value, status_type status,
                                logic last);
         list_result_type r;
         r.value  = value;
         r.status = status;
         r.last   = last;
         expected_q.push_back(r);
      endfunction

      // update the list copy for one accepted request and queue its results
      function void note_request(logic cmd, logic signed [DATA_W-1:0] value);
         int pos;
         if (cmd == CMD_INSERT) begin
            if (count >= DEPTH) begin
               push_result(value, STAT_FULL, 1'b1);
            end else begin
               // goes after every stored value that is smaller
               pos = 0;
               while (pos < count && entries[pos] < value) pos++;
               for (int i = count; i > pos; i--) entries[i] = entries[i-1];
               entries[pos] = value;
               count++;
               push_result(value, STAT_INSERTED, 1'b1);
            end
         end else if (count == 0) begin
            push_result('0, STAT_EMPTY, 1'b1);
         end else begin
            for (int i = 0; i < count; i++)
               push_result(entries[i], STAT_ELEMENT, i == count - 1);
         end
      endfunction

      function void flag_mismatch(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%s", msg);
      endfunction

      // compare one accepted rsp transaction with the oldest prediction
      function void check_result(logic signed [DATA_W-1:0] value, status_type status,
                                 logic last);
         list_result_type r;
         if (expected_q.size() == 0) begin
            flag_mismatch($sformatf("unexpected result: value=%0d status=%s last=%0b",
                                    value, status.name(), last));
            return;
         end
         r = expected_q.pop_front();
         if (value !== r.value || status !== r.status || last !== r.last)
            flag_mismatch($sformatf({"result mismatch: expected value=%0d status=%s ",
                                     "last=%0b, got value=%0d status=%s last=%0b"},
                                    r.value, r.status.name(), r.last,
                                    value, status.name(), last));
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

   endclass

endpackage

module tb;

   timeunit 1ns;
   timeprecision 1ps;

   import sli_pkg::*;
   import sli_tb_pkg::*;

   localparam int CAPACITY       = SB_DEPTH;
   localparam int RANDOM_ITEMS   = 110;
   localparam int HOLD_AT        = 35;
   localparam int PAUSE_AT       = 75;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 3000;

   localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [31:0] value
   logic [0:0]  req_tuser  = '0;   // [0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [31:0] value_out
   logic [1:0]  rsp_tuser;         // [1:0] status
   logic        rsp_tlast;

   logic        hold_rsp    = 1'b0;
   int          idle_cycles = 0;
   int          burst_left  = 0;

   list_scoreboard sb = new();

   sorted_list_insert_top #(
      .CAPACITY (CAPACITY)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 10 ns clock
   initial begin
      forever #5 clock = ~clock;
   end

   // transaction monitor, prediction and idle counter
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_tvalid && req_tready) sb.note_request(req_tuser[0], req_tdata);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata, status_type'(rsp_tuser), rsp_tlast);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // watchdog on stretches with no transaction at all
   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("[sorted_list_insert_top] ERROR");
      $finish;
   end

   // receiver: a changing stall rate, plus one long hold-off
   initial begin
      int stall_pct;
      int pattern_left;
      stall_pct    = 0;
      pattern_left = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            hold_rsp   <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (pattern_left == 0) begin
               case ($urandom_range(0, 3))
                  0:       stall_pct = 0;
                  1:       stall_pct = 20;
                  2:       stall_pct = 50;
                  default: stall_pct = 85;
               endcase
               pattern_left = 64;
            end
            pattern_left--;
            rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // offer one request, with a random gap before each new burst
   task automatic send_item(input logic cmd, input logic signed [DATA_W-1:0] value);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid   <= 1'b1;
      req_tuser[0] <= cmd;
      req_tdata    <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
   endtask

   // stop sending and wait until every predicted result has arrived
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
      @(posedge clock);
      burst_left = 0;
   endtask

   // mostly random values, with extremes and already stored values mixed in
   function automatic logic signed [DATA_W-1:0] pick_value();
      logic signed [DATA_W-1:0] v;
      v = $urandom;
      case ($urandom_range(0, 7))
         0: begin
            case ($urandom_range(0, 4))
               0:       v = VALUE_MIN;
               1:       v = VALUE_MAX;
               2:       v = '0;
               3:       v = -1;
               default: v = 1;
            endcase
         end
         1: if (sb.count > 0) v = sb.entries[$urandom_range(0, sb.count - 1)];
         default: ;
      endcase
      return v;
   endfunction

   // stimulus and end of run
   initial begin
      logic cmd;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty readout, extremes, equal values, back-to-back readouts
      send_item(CMD_READOUT, $urandom);
      send_item(CMD_INSERT, '0);
      send_item(CMD_INSERT, VALUE_MAX);
      send_item(CMD_INSERT, VALUE_MIN);
      send_item(CMD_INSERT, -1);
      send_item(CMD_INSERT, 1);
      send_item(CMD_INSERT, '0);
      send_item(CMD_READOUT, $urandom);
      send_item(CMD_INSERT, VALUE_MAX);
      send_item(CMD_INSERT, VALUE_MIN);
      send_item(CMD_READOUT, '0);
      send_item(CMD_READOUT, '1);

      // random: list fills up, then rejected inserts and full readouts
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == HOLD_AT) hold_rsp <= 1'b1;
         if (k == PAUSE_AT) drain_results();
         cmd = ($urandom_range(0, 3) == 0) ? CMD_READOUT : CMD_INSERT;
         send_item(cmd, pick_value());
      end

      drain_results();
      repeat (2 * CAPACITY + 8) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("[sorted_list_insert_top] OK");
      else
         $display("[sorted_list_insert_top] ERROR");
      $finish;
   end

endmodule
